// ===== design/bdn_pkg.sv =====
// ----------------------------------------------------------------------------
// bdn_pkg
// Shared constants and types for the box descriptor L2-Hys normalizer.
// ----------------------------------------------------------------------------
package bdn_pkg;

    localparam int ELEMENT_COUNT = 32;
    localparam int CORNER_WIDTH  = 28;
    localparam int FRACTION_BITS = 15;

    localparam int IDX_W   = $clog2(ELEMENT_COUNT);
    localparam int SQ_W    = 60;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int PROD_W  = 2 * CORNER_WIDTH;
    localparam int Q_W     = FRACTION_BITS + 1;
    localparam int DIV_W   = ROOT_W + Q_W;
    localparam int CLAMP_W = 15;
    localparam int INDEX_W = 5;
    localparam int VALUE_W = 16;

    localparam logic [CLAMP_W-1:0] CLAMP_RESET = 15'd11585;

    typedef logic [CORNER_WIDTH-1:0] corner_t;
    typedef logic [IDX_W-1:0]        idx_t;

endpackage

// ===== design/bdn_if.sv =====
// ----------------------------------------------------------------------------
// bdn_if
// Valid/ready channels carrying corner transactions and normalized elements.
// ----------------------------------------------------------------------------
interface bdn_in_if;
    logic                   valid;
    logic                   ready;
    bdn_pkg::corner_t       corner_top_left;
    bdn_pkg::corner_t       corner_bottom_left;
    bdn_pkg::corner_t       corner_top_right;
    bdn_pkg::corner_t       corner_bottom_right;

    modport source (output valid, output corner_top_left, output corner_bottom_left,
                    output corner_top_right, output corner_bottom_right, input ready);
    modport sink (input valid, input corner_top_left, input corner_bottom_left,
                  input corner_top_right, input corner_bottom_right, output ready);
endinterface

interface bdn_out_if;
    logic                              valid;
    logic                              ready;
    logic [bdn_pkg::INDEX_W-1:0]       element_index;
    logic signed [bdn_pkg::VALUE_W-1:0] norm_value;
    logic                              last_element;

    modport source (output valid, output element_index, output norm_value,
                    output last_element, input ready);
    modport sink (input valid, input element_index, input norm_value,
                  input last_element, output ready);
endinterface

// ===== design/bdn_mem.sv =====
// ----------------------------------------------------------------------------
// bdn_mem
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bdn_mem
(
    input  logic             clk,
    input  logic             we,
    input  bdn_pkg::idx_t    waddr,
    input  bdn_pkg::corner_t wdata,
    input  bdn_pkg::idx_t    raddr,
    output bdn_pkg::corner_t rdata
);

    bdn_pkg::corner_t mem [bdn_pkg::ELEMENT_COUNT];
    bdn_pkg::corner_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bdn_sqrt.sv =====
// ----------------------------------------------------------------------------
// bdn_sqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module bdn_sqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [bdn_pkg::SQ_W-1:0]     operand,
    output logic                         done,
    output logic [bdn_pkg::ROOT_W-1:0]   root
);

    logic [bdn_pkg::SQ_W-1:0] v_reg, v_next;
    logic [bdn_pkg::SQ_W-1:0] r_reg, r_next;
    logic [bdn_pkg::SQ_W-1:0] bit_reg, bit_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [bdn_pkg::SQ_W:0]   trial;

    always_comb
    begin
        trial     = {1'b0, r_reg} + {1'b0, bit_reg};
        v_next    = v_reg;
        r_next    = r_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            v_next    = operand;
            r_next    = '0;
            bit_next  = bdn_pkg::SQ_W'(1) << (bdn_pkg::SQ_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if ({1'b0, v_reg} >= trial)
            begin
                v_next = v_reg - trial[bdn_pkg::SQ_W-1:0];
                r_next = (r_reg >> 1) + bit_reg;
            end
            else
            begin
                r_next = r_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        r_reg   <= r_next;
        bit_reg <= bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[bdn_pkg::ROOT_W-1:0];

endmodule

// ===== design/bdn_div.sv =====
// ----------------------------------------------------------------------------
// bdn_div
// Iterative restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bdn_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bdn_pkg::DIV_W-1:0]   dividend,
    input  logic [bdn_pkg::ROOT_W-1:0]  divisor,
    output logic                        done,
    output logic [bdn_pkg::Q_W-1:0]     quotient
);

    localparam int CNT_W = $clog2(bdn_pkg::Q_W);

    logic [bdn_pkg::DIV_W-1:0] rem_reg, rem_next;
    logic [bdn_pkg::DIV_W-1:0] dsr_reg, dsr_next;
    logic [bdn_pkg::Q_W-1:0]   q_reg, q_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;
    logic                      done_reg, done_next;

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = bdn_pkg::DIV_W'(divisor) << (bdn_pkg::Q_W - 1);
            q_next    = '0;
            cnt_next  = CNT_W'(bdn_pkg::Q_W - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsr_reg)
            begin
                rem_next = rem_reg - dsr_reg;
                q_next   = {q_reg[bdn_pkg::Q_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[bdn_pkg::Q_W-2:0], 1'b0};
            end
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
        cnt_reg <= cnt_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ===== design/box_descriptor_l2hys_normalizer.sv =====
// ----------------------------------------------------------------------------
// box_descriptor_l2hys_normalizer
// Box sums from corner transactions, then L2-Hys normalization of the vector.
//
//   channel    dir   transaction
//   corners    in    four summed-area corners of one cell channel
//   elements   out   element index, normalized value, last flag
//   cfg        in    clamp limit write
//
// each corner transaction is stored, squared and accumulated
// after the 32nd: square root, then per element
// (read, load, divide, square, accumulate), another square root,
// then per element (read, load, divide, emit)
// corners.ready is high only while idle; emits wait on elements.ready
// reset clears the sequencer and counters and restores the clamp default
// ----------------------------------------------------------------------------
module box_descriptor_l2hys_normalizer
(
    input  logic                            clk,
    input  logic                            rst_n,
    bdn_in_if.sink                          corners,
    bdn_out_if.source                       elements,
    input  logic                            cfg_we,
    input  logic [bdn_pkg::CLAMP_W-1:0]     cfg_wdata
);

    localparam int CW = bdn_pkg::CORNER_WIDTH;

    typedef enum logic [13:0] {
        S_IDLE = 14'b00000000000001,
        S_SQ   = 14'b00000000000010,
        S_ACC  = 14'b00000000000100,
        S_RT1  = 14'b00000000001000,
        S_RD1  = 14'b00000000010000,
        S_LD1  = 14'b00000000100000,
        S_DV1  = 14'b00000001000000,
        S_SQ2  = 14'b00000010000000,
        S_AC2  = 14'b00000100000000,
        S_RT2  = 14'b00001000000000,
        S_RD2  = 14'b00010000000000,
        S_LD2  = 14'b00100000000000,
        S_DV2  = 14'b01000000000000,
        S_EMIT = 14'b10000000000000
    } state_t;

    state_t                          state_reg, state_next;
    bdn_pkg::idx_t                   idx_reg, idx_next;
    logic [bdn_pkg::SQ_W-1:0]        acc_reg, acc_next;
    logic [bdn_pkg::CLAMP_W-1:0]     clamp_reg;
    logic                            out_valid_reg, out_valid_next;
    logic [bdn_pkg::INDEX_W-1:0]     out_index_reg, out_index_next;
    logic [bdn_pkg::VALUE_W-1:0]     out_value_reg, out_value_next;
    logic                            out_last_reg, out_last_next;

    bdn_pkg::corner_t                mag_reg, mag_next;
    logic [bdn_pkg::PROD_W-1:0]      prod_reg, prod_next;
    logic [bdn_pkg::ROOT_W-1:0]      n1_reg, n1_next;
    logic [bdn_pkg::ROOT_W-1:0]      n2_reg, n2_next;
    logic                            neg_reg, neg_next;
    logic [bdn_pkg::Q_W-1:0]         q_reg, q_next;

    bdn_pkg::corner_t                box;
    bdn_pkg::corner_t                rdata;
    bdn_pkg::corner_t                rd_mag;
    logic                            mem_we;
    bdn_pkg::corner_t                mem_wdata;
    logic [bdn_pkg::SQ_W:0]          acc_sum;
    logic                            sqrt_start, sqrt_done;
    logic [bdn_pkg::SQ_W-1:0]        sqrt_operand;
    logic [bdn_pkg::ROOT_W-1:0]      root;
    logic                            div_start, div_done;
    logic [bdn_pkg::DIV_W-1:0]       div_dividend;
    logic [bdn_pkg::ROOT_W-1:0]      div_divisor;
    logic [bdn_pkg::Q_W-1:0]         quotient;
    logic [bdn_pkg::CLAMP_W-1:0]     a_val;
    logic                            out_free;
    logic                            is_last;
    logic [bdn_pkg::Q_W-1:0]         q_sat;

    assign box    = corners.corner_bottom_right - corners.corner_bottom_left
                  + corners.corner_top_left - corners.corner_top_right;
    assign rd_mag = rdata[CW-1] ? (~rdata + 1'b1) : rdata;
    assign acc_sum  = {1'b0, acc_reg} + (bdn_pkg::SQ_W+1)'(prod_reg);
    assign out_free = !out_valid_reg || elements.ready;
    assign is_last  = (idx_reg == bdn_pkg::IDX_W'(bdn_pkg::ELEMENT_COUNT - 1));
    assign sqrt_operand = acc_sum[bdn_pkg::SQ_W] ? '1 : acc_sum[bdn_pkg::SQ_W-1:0];

    always_comb
    begin
        if (n1_reg == '0)
        begin
            a_val = '0;
        end
        else if (quotient > bdn_pkg::Q_W'(clamp_reg))
        begin
            a_val = clamp_reg;
        end
        else
        begin
            a_val = quotient[bdn_pkg::CLAMP_W-1:0];
        end
    end

    always_comb
    begin
        if (n2_reg == '0)
        begin
            q_sat = '0;
        end
        else if (neg_reg)
        begin
            q_sat = (q_reg > bdn_pkg::Q_W'(32768)) ? bdn_pkg::Q_W'(32768) : q_reg;
        end
        else
        begin
            q_sat = (q_reg > bdn_pkg::Q_W'(32767)) ? bdn_pkg::Q_W'(32767) : q_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        prod_next      = mag_reg * mag_reg;
        n1_next        = n1_reg;
        n2_next        = n2_reg;
        neg_next       = neg_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !elements.ready;
        out_index_next = out_index_reg;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        mem_we         = 1'b0;
        mem_wdata      = box;
        sqrt_start     = 1'b0;
        div_start      = 1'b0;
        div_dividend   = bdn_pkg::DIV_W'(rd_mag) << bdn_pkg::FRACTION_BITS;
        div_divisor    = n1_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (corners.valid)
                begin
                    mem_we     = 1'b1;
                    mag_next   = box[CW-1] ? (~box + 1'b1) : box;
                    state_next = S_SQ;
                end
            end
            S_SQ:
            begin
                state_next = S_ACC;
            end
            S_ACC:
            begin
                acc_next = acc_sum[bdn_pkg::SQ_W] ? '1 : acc_sum[bdn_pkg::SQ_W-1:0];
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_RT1;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RT1:
            begin
                if (sqrt_done)
                begin
                    n1_next    = root;
                    acc_next   = '0;
                    state_next = S_RD1;
                end
            end
            S_RD1:
            begin
                state_next = S_LD1;
            end
            S_LD1:
            begin
                neg_next   = rdata[CW-1];
                div_start  = 1'b1;
                state_next = S_DV1;
            end
            S_DV1:
            begin
                if (div_done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = {neg_reg, (CW-1)'(a_val)};
                    mag_next   = CW'(a_val);
                    state_next = S_SQ2;
                end
            end
            S_SQ2:
            begin
                state_next = S_AC2;
            end
            S_AC2:
            begin
                acc_next = acc_sum[bdn_pkg::SQ_W] ? '1 : acc_sum[bdn_pkg::SQ_W-1:0];
                if (is_last)
                begin
                    idx_next   = '0;
                    state_next = S_RT2;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_RD1;
                end
            end
            S_RT2:
            begin
                if (sqrt_done)
                begin
                    n2_next    = root;
                    acc_next   = '0;
                    state_next = S_RD2;
                end
            end
            S_RD2:
            begin
                state_next = S_LD2;
            end
            S_LD2:
            begin
                neg_next     = rdata[CW-1];
                div_dividend = bdn_pkg::DIV_W'(rdata[bdn_pkg::CLAMP_W-1:0])
                               << bdn_pkg::FRACTION_BITS;
                div_divisor  = n2_reg;
                div_start    = 1'b1;
                state_next   = S_DV2;
            end
            S_DV2:
            begin
                if (div_done)
                begin
                    q_next     = quotient;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = bdn_pkg::INDEX_W'(idx_reg);
                    out_value_next = neg_reg ? bdn_pkg::VALUE_W'(~q_sat + 1'b1)
                                             : bdn_pkg::VALUE_W'(q_sat);
                    out_last_next  = is_last;
                    if (is_last)
                    begin
                        idx_next   = '0;
                        acc_next   = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_RD2;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        sqrt_start = (state_reg == S_ACC || state_reg == S_AC2) && is_last;
        if (sqrt_start)
        begin
            acc_next = acc_sum[bdn_pkg::SQ_W] ? '1 : acc_sum[bdn_pkg::SQ_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            acc_reg       <= '0;
            clamp_reg     <= bdn_pkg::CLAMP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                clamp_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        prod_reg      <= prod_next;
        n1_reg        <= n1_next;
        n2_reg        <= n2_next;
        neg_reg       <= neg_next;
        q_reg         <= q_next;
        out_index_reg <= out_index_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
    end

    bdn_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_reg),
        .wdata (mem_wdata),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    bdn_sqrt u_sqrt
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_operand),
        .done    (sqrt_done),
        .root    (root)
    );

    bdn_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    assign corners.ready          = (state_reg == S_IDLE);
    assign elements.valid         = out_valid_reg;
    assign elements.element_index = out_index_reg;
    assign elements.norm_value    = out_value_reg;
    assign elements.last_element  = out_last_reg;

endmodule
